/* rtl/assert_macros.svh */
// Assertion macros shared by the transcoder RTL.
// Depends on nothing; the bodies compile away when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// The property must hold at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: property does not hold");
// The condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed: forbidden condition seen");
`else
`define ASSERT_HOLDS(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

/* rtl/u8u16_pkg.sv */
// Types and constants of the UTF-8 to UTF-16 transcoder.
// Depends on nothing; used by every module of the block.
package u8u16_pkg;

    localparam logic [15:0] REPLACEMENT   = 16'hFFFD;
    localparam logic [20:0] SUPP_BASE     = 21'h10000;
    localparam logic [15:0] SURR_HI_BASE  = 16'hD800;
    localparam logic [5:0]  SURR_LO_TOP   = 6'b110111;

    // Kind of a byte decoded as the start of a sequence.
    typedef enum logic [2:0] {
        LEAD_ASCII,
        LEAD_TWO,
        LEAD_THREE,
        LEAD_FOUR,
        LEAD_BAD
    } lead_kind_t;

    // One entry of the job queue: the code units caused by one byte.
    typedef struct packed {
        logic        two_units;
        logic [15:0] unit0;
        logic [15:0] unit1;
        logic        fin;
    } job_t;

endpackage

/* rtl/u8u16_byte_if.sv */
// Byte channel into the transcoder: valid/ready handshake with the UTF-8 payload.
// Depends on nothing.
interface u8u16_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       final_byte;

    modport source (output valid, output in_byte, output final_byte, input ready);
    modport sink   (input valid, input in_byte, input final_byte, output ready);
endinterface

/* rtl/u8u16_unit_if.sv */
// Code unit channel out of the transcoder: valid/ready handshake with UTF-16 payload.
// Depends on nothing.
interface u8u16_unit_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        last_of_run;
    logic        stream_done;

    modport source (output valid, output code_unit, output last_of_run,
                    output stream_done, input ready);
    modport sink   (input valid, input code_unit, input last_of_run,
                    input stream_done, output ready);
endinterface

/* rtl/u8u16_front.sv */
// Front end: accepts bytes, tracks the pending sequence and builds one job per byte that causes output.
// Depends on u8u16_pkg, u8u16_byte_if and assert_macros.svh.
`include "assert_macros.svh"

module u8u16_front
    import u8u16_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    u8u16_byte_if.sink    utf8,
    input  logic          queue_full,
    output logic          push,
    output job_t          job
);

    logic [20:0] partial_reg, partial_next;
    logic [1:0]  due_reg, due_next;

    logic        accept;
    logic [7:0]  b;
    logic        is_cont;
    lead_kind_t  kind;
    logic [1:0]  due_less;
    logic [20:0] point;
    logic [20:0] offset;
    logic        complete;
    logic        broken;
    logic        lead_unit_vld;
    logic [15:0] lead_unit;

    assign b           = utf8.in_byte;
    assign utf8.ready  = !queue_full;
    assign accept      = utf8.valid && !queue_full;
    assign is_cont     = (b[7:6] == 2'b10);
    assign due_less    = due_reg - 2'd1;
    assign point       = {partial_reg[14:0], b[5:0]};
    assign offset      = point - SUPP_BASE;

    always_comb
    begin
        unique case (b) inside
            8'b0???????: kind = LEAD_ASCII;
            8'b110?????: kind = LEAD_TWO;
            8'b1110????: kind = LEAD_THREE;
            8'b11110???: kind = LEAD_FOUR;
            default:     kind = LEAD_BAD;
        endcase
    end

    // Next state and the units this byte causes.
    always_comb
    begin
        partial_next  = partial_reg;
        due_next      = due_reg;
        complete      = 1'b0;
        broken        = 1'b0;
        lead_unit_vld = 1'b0;
        lead_unit     = REPLACEMENT;
        job           = '0;
        job.fin       = utf8.final_byte;

        if (due_reg != 2'd0 && is_cont)
        begin
            // A continuation extends the pending point by six bits.
            partial_next = point;
            due_next     = due_less;
            if (due_less == 2'd0)
            begin
                complete     = 1'b1;
                partial_next = '0;
            end
        end
        else
        begin
            // A non-continuation breaks any pending sequence, then acts as a lead.
            broken = (due_reg != 2'd0);
            unique case (kind)
                LEAD_ASCII:
                begin
                    partial_next  = '0;
                    due_next      = 2'd0;
                    lead_unit_vld = 1'b1;
                    lead_unit     = {8'h00, b};
                end
                LEAD_TWO:
                begin
                    partial_next = {16'h0000, b[4:0]};
                    due_next     = 2'd1;
                end
                LEAD_THREE:
                begin
                    partial_next = {17'd0, b[3:0]};
                    due_next     = 2'd2;
                end
                LEAD_FOUR:
                begin
                    partial_next = {18'd0, b[2:0]};
                    due_next     = 2'd3;
                end
                default:
                begin
                    partial_next  = '0;
                    due_next      = 2'd0;
                    lead_unit_vld = 1'b1;
                end
            endcase
        end

        // A sequence cut off by the end of the stream gives one replacement.
        if (utf8.final_byte && due_next != 2'd0 && !lead_unit_vld && !complete)
        begin
            lead_unit_vld = 1'b1;
            lead_unit     = REPLACEMENT;
        end

        if (complete)
        begin
            if (point[20:16] != 5'd0)
            begin
                job.two_units = 1'b1;
                job.unit0     = SURR_HI_BASE + {5'd0, offset[20:10]};
                job.unit1     = {SURR_LO_TOP, offset[9:0]};
            end
            else
            begin
                job.unit0 = point[15:0];
            end
        end
        else if (broken)
        begin
            job.unit0     = REPLACEMENT;
            job.unit1     = lead_unit;
            job.two_units = lead_unit_vld;
        end
        else
        begin
            job.unit0 = lead_unit;
        end

        if (utf8.final_byte)
        begin
            partial_next = '0;
            due_next     = 2'd0;
        end
    end

    assign push = accept && (complete || broken || lead_unit_vld);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            due_reg     <= 2'd0;
        end
        else if (accept)
        begin
            partial_reg <= partial_next;
            due_reg     <= due_next;
        end
    end

    `ASSERT_HOLDS(a_final_gives_job, clk, rst_n, (accept && utf8.final_byte) |-> push)
    `ASSERT_HOLDS(a_final_clears, clk, rst_n, (accept && utf8.final_byte) |=> (due_reg == 2'd0))

endmodule

/* rtl/u8u16_queue.sv */
// Short job queue between the front end and the back end.
// Depends on u8u16_pkg and assert_macros.svh.
`include "assert_macros.svh"

module u8u16_queue
    import u8u16_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head,
    output logic full,
    output logic empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `ASSERT_NEVER(a_no_overflow, clk, rst_n, push && full && !pop)
    `ASSERT_NEVER(a_no_underflow, clk, rst_n, pop && empty)

endmodule

/* rtl/u8u16_back.sv */
// Back end: sends the units of each queued job, one per word, through an output register.
// Depends on u8u16_pkg, u8u16_unit_if and assert_macros.svh.
`include "assert_macros.svh"

module u8u16_back
    import u8u16_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  job_t          head,
    input  logic          empty,
    output logic          pop,
    u8u16_unit_if.source  utf16
);

    logic        out_valid_reg, out_valid_next;
    logic        phase_reg, phase_next;
    logic [15:0] unit_reg, unit_next;
    logic        last_reg, last_next;
    logic        done_reg, done_next;
    logic        load_en;

    assign load_en = !out_valid_reg || utf16.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        phase_next     = phase_reg;
        unit_next      = unit_reg;
        last_next      = last_reg;
        done_next      = done_reg;
        pop            = 1'b0;
        if (load_en)
        begin
            out_valid_next = !empty;
            if (!empty)
            begin
                if (phase_reg)
                begin
                    // Second unit of the head job.
                    unit_next  = head.unit1;
                    last_next  = 1'b1;
                    done_next  = head.fin;
                    phase_next = 1'b0;
                    pop        = 1'b1;
                end
                else
                begin
                    unit_next  = head.unit0;
                    last_next  = !head.two_units;
                    done_next  = !head.two_units && head.fin;
                    phase_next = head.two_units;
                    pop        = !head.two_units;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unit_reg <= unit_next;
        last_reg <= last_next;
        done_reg <= done_next;
    end

    assign utf16.valid       = out_valid_reg;
    assign utf16.code_unit   = unit_reg;
    assign utf16.last_of_run = last_reg;
    assign utf16.stream_done = done_reg;

    `ASSERT_HOLDS(a_phase_has_job, clk, rst_n, phase_reg |-> !empty)

endmodule

/* rtl/utf8_to_utf16_transcoder.sv */
// Top level of the UTF-8 to UTF-16 transcoder: front end, job queue and back end.
// Depends on u8u16_pkg, u8u16_byte_if, u8u16_unit_if and the three submodules.

// The transcoder takes one UTF-8 byte per word on the utf8 channel and sends
// UTF-16 code units, one per word, on the utf16 channel. The front end accepts
// a byte in every cycle in which the job queue has room, so it takes one byte
// per clock while the queue is not full. Each byte that causes output becomes
// one job in the queue; bytes that only extend a pending sequence cause
// nothing. The back end sends one code unit per clock from its output register
// while the receiver is ready, so a byte that gives a surrogate pair, or a
// replacement followed by a second unit, stays at the head of the queue until
// both units are sent; the queue of QUEUE_DEPTH jobs absorbs such bursts, and
// the front end stalls only when it is full. A code unit passes through the job
// queue and then the output register before it is valid on the output.
// The unit 0xFFFD replaces an invalid lead byte, a stray continuation
// byte, a sequence broken by a non-continuation byte (which is then decoded
// again as a new lead) and a sequence cut off by the end of the stream.
// last_of_run marks the last unit caused by a byte, and stream_done the last
// unit of a byte flagged with final_byte, after which decoding starts afresh.
// No overlong, surrogate or range checks are made.
module utf8_to_utf16_transcoder
    import u8u16_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic          clk,
    input  logic          rst_n,
    u8u16_byte_if.sink    utf8,
    u8u16_unit_if.source  utf16
);

    logic push;
    logic pop;
    logic full;
    logic empty;
    job_t push_job;
    job_t head;

    // Decodes bytes and keeps the partial code point.
    u8u16_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .utf8       (utf8),
        .queue_full (full),
        .push       (push),
        .job        (push_job)
    );

    // Decouples decoding from delivery of the code units.
    u8u16_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .full     (full),
        .empty    (empty)
    );

    // Sends the units of each job in order.
    u8u16_back u_back
    (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .empty (empty),
        .pop   (pop),
        .utf16 (utf16)
    );

endmodule

/* tb/tb.sv */
// Self-checking testbench for the UTF-8 to UTF-16 transcoder.
// Depends on u8u16_pkg, u8u16_byte_if, u8u16_unit_if and utf8_to_utf16_transcoder.
`timescale 1ns / 100ps

module tb;
    import u8u16_pkg::*;

    localparam int          DIRECTED_COUNT = 27;
    localparam int          RANDOM_BYTES   = 700;
    localparam int          CYCLE_LIMIT    = 200000;
    localparam int          DRAIN_CYCLES   = 20;
    localparam logic [15:0] LOW_SURR_BASE  = 16'hDC00;

    // One byte word as the driver sends it. Where typed is set, the code units
    // are written out in the table and stand in for the decoder's own answer.
    typedef struct packed {
        logic [7:0]  in_byte;
        logic        final_byte;
        logic        typed;
        logic [1:0]  unit_count;
        logic [15:0] unit0;
        logic [15:0] unit1;
    } utf8_word_t;

    // One code unit that the transcoder still owes us.
    typedef struct packed {
        logic [15:0] code_unit;
        logic        last_of_run;
        logic        stream_done;
    } unit_due_t;

    logic clk;
    logic rst_n;

    u8u16_byte_if utf8_ch ();
    u8u16_unit_if utf16_ch ();

    utf8_to_utf16_transcoder uut (
        .clk   (clk),
        .rst_n (rst_n),
        .utf8  (utf8_ch),
        .utf16 (utf16_ch)
    );

    // The clock starts low, so the first rising edge falls at 5 ns.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Decoder state, kept apart from the block's own registers. It mirrors
    // what the transcoder must hold between bytes: the code point bits
    // gathered so far and the number of continuation bytes still owed.
    // ------------------------------------------------------------------
    logic [20:0] gathered_bits;
    logic [1:0]  cont_left;
    logic [15:0] byte_units [2];
    int          byte_unit_count;

    unit_due_t   units_due [$];
    utf8_word_t  directed_words [DIRECTED_COUNT];
    utf8_word_t  current_word;

    int  cycle_count;
    int  mismatches;
    int  bytes_sent;
    int  units_checked;
    int  surrogates_seen;
    int  replacements_seen;
    int  stream_ends_seen;
    bit  no_stalls;

    // A byte never causes more than two units; anything beyond that is dropped,
    // as the block has no room to send it either.
    function automatic void add_unit(input logic [15:0] value);
        if (byte_unit_count < 2)
        begin
            byte_units[byte_unit_count] = value;
            byte_unit_count++;
        end
    endfunction

    // Code points above the basic plane go out as a high and a low surrogate.
    function automatic void add_code_point(input logic [20:0] point);
        logic [20:0] offset;
        if (point <= 21'h00FFFF)
        begin
            add_unit(point[15:0]);
        end
        else
        begin
            offset = point - SUPP_BASE;
            add_unit(SURR_HI_BASE + {5'd0, offset[20:10]});
            add_unit(LOW_SURR_BASE + {6'd0, offset[9:0]});
        end
    endfunction

    // Works out the code units that one accepted byte must cause, and moves
    // the decoder state on. The units land in byte_units.
    function automatic void decode_byte(input logic [7:0] value, input logic fin);
        logic as_lead;
        as_lead = 1'b1;
        byte_unit_count = 0;

        if (cont_left != 2'd0)
        begin
            if (value[7:6] == 2'b10)
            begin
                // Continuation: six more bits, and the point is out once complete.
                as_lead = 1'b0;
                gathered_bits = {gathered_bits[14:0], value[5:0]};
                cont_left = cont_left - 2'd1;
                if (cont_left == 2'd0)
                begin
                    add_code_point(gathered_bits);
                    gathered_bits = '0;
                end
            end
            else
            begin
                // The pending sequence is broken; the byte is read again as a lead.
                add_unit(REPLACEMENT);
                cont_left = 2'd0;
                gathered_bits = '0;
            end
        end

        if (as_lead)
        begin
            casez (value)
                8'b0???????:
                begin
                    add_code_point({13'd0, value});
                end
                8'b110?????:
                begin
                    gathered_bits = {16'd0, value[4:0]};
                    cont_left = 2'd1;
                end
                8'b1110????:
                begin
                    gathered_bits = {17'd0, value[3:0]};
                    cont_left = 2'd2;
                end
                8'b11110???:
                begin
                    gathered_bits = {18'd0, value[2:0]};
                    cont_left = 2'd3;
                end
                default:
                begin
                    // Stray continuation or a lead of five or more ones.
                    add_unit(REPLACEMENT);
                end
            endcase
        end

        // At the end of a stream an unfinished sequence costs one replacement,
        // and decoding starts afresh with the next byte.
        if (fin)
        begin
            if (cont_left != 2'd0)
                add_unit(REPLACEMENT);
            cont_left = 2'd0;
            gathered_bits = '0;
        end
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0d] mismatch: %s", cycle_count, what);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Monitor. Both channels are sampled at the rising edge. An accepted byte
    // word queues the units it must cause; an accepted code unit word is
    // checked against the oldest unit still owed.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        unit_due_t due;
        logic [15:0] units [2];
        int count;
        if (rst_n)
        begin
            if (utf8_ch.valid && utf8_ch.ready)
            begin
                decode_byte(utf8_ch.in_byte, utf8_ch.final_byte);
                if (current_word.typed)
                begin
                    count = current_word.unit_count;
                    units[0] = current_word.unit0;
                    units[1] = current_word.unit1;
                end
                else
                begin
                    count = byte_unit_count;
                    units = byte_units;
                end
                for (int k = 0; k < count; k++)
                begin
                    due.code_unit   = units[k];
                    due.last_of_run = (k == count - 1);
                    due.stream_done = (k == count - 1) && utf8_ch.final_byte;
                    units_due.insert(units_due.size(), due);
                end
            end

            if (utf16_ch.valid && utf16_ch.ready)
            begin
                units_checked++;
                if (utf16_ch.code_unit[15:11] == 5'b11011)
                    surrogates_seen++;
                if (utf16_ch.code_unit == REPLACEMENT)
                    replacements_seen++;
                if (utf16_ch.stream_done)
                    stream_ends_seen++;

                if (units_due.size() == 0)
                begin
                    report_mismatch($sformatf("unit %h arrived with nothing owed",
                                              utf16_ch.code_unit));
                end
                else
                begin
                    due = units_due.pop_front();
                    if (utf16_ch.code_unit !== due.code_unit)
                        report_mismatch($sformatf("code_unit %h, wanted %h",
                                                  utf16_ch.code_unit, due.code_unit));
                    if (utf16_ch.last_of_run !== due.last_of_run)
                        report_mismatch($sformatf("last_of_run %b, wanted %b on unit %h",
                                                  utf16_ch.last_of_run, due.last_of_run,
                                                  due.code_unit));
                    if (utf16_ch.stream_done !== due.stream_done)
                        report_mismatch($sformatf("stream_done %b, wanted %b on unit %h",
                                                  utf16_ch.stream_done, due.stream_done,
                                                  due.code_unit));
                end
            end
        end
    end

    // Watchdog: a run that has not ended by now has hung.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Run stopped at cycle %0d with %0d units still owed.",
                     cycle_count, units_due.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // The receiver holds ready low in about one cycle in six, except in the
    // stretch where the sender runs flat out too.
    always @(negedge clk)
    begin
        utf16_ch.ready <= no_stalls || ($urandom_range(99) >= 17);
    end

    // Sends one byte word: optional idle cycles first, then valid stays high
    // until the block takes the word. Called and left at a falling edge.
    task automatic send_word(input utf8_word_t w);
        while (!no_stalls && ($urandom_range(99) < 17))
        begin
            utf8_ch.valid <= 1'b0;
            @(negedge clk);
        end
        current_word = w;
        utf8_ch.valid      <= 1'b1;
        utf8_ch.in_byte    <= w.in_byte;
        utf8_ch.final_byte <= w.final_byte;
        do
            @(posedge clk);
        while (!utf8_ch.ready);
        bytes_sent++;
        @(negedge clk);
    endtask

    // Builds and sends one short run of bytes. Most runs are well-formed
    // sequences with random payload; some are cut short, either by the end of
    // the stream or by a byte that is not a continuation; the rest is noise.
    task automatic send_random_run();
        logic [8:0]  run_bytes [$];
        lead_kind_t  kind;
        utf8_word_t  w;
        int          roll;
        int          conts;
        int          kept;
        logic [7:0]  value;
        roll = $urandom_range(99);
        kind = lead_kind_t'($urandom_range(3));
        // The lead kinds are numbered by the continuation bytes they need.
        conts = int'(kind);

        if (roll < 15)
        begin
            run_bytes.insert(run_bytes.size(),
                             {($urandom_range(11) == 0), 8'($urandom_range(255))});
        end
        else
        begin
            case (kind)
                LEAD_ASCII: value = {1'b0, 7'($urandom)};
                LEAD_TWO:   value = {3'b110, 5'($urandom)};
                LEAD_THREE: value = {4'b1110, 4'($urandom)};
                default:    value = {5'b11110, 3'($urandom)};
            endcase
            run_bytes.insert(run_bytes.size(), {1'b0, value});

            kept = conts;
            if (roll < 32 && conts > 0)
                kept = $urandom_range(conts - 1);
            for (int k = 0; k < kept; k++)
                run_bytes.insert(run_bytes.size(), {1'b0, 2'b10, 6'($urandom)});

            if (kept < conts)
            begin
                if ($urandom_range(1) == 0)
                begin
                    run_bytes[run_bytes.size() - 1][8] = 1'b1;
                end
                else
                begin
                    value = 8'($urandom_range(255));
                    if (value[7:6] == 2'b10)
                        value[6] = 1'b1;
                    run_bytes.insert(run_bytes.size(),
                                     {($urandom_range(11) == 0), value});
                end
            end
            else if ($urandom_range(11) == 0)
            begin
                run_bytes[run_bytes.size() - 1][8] = 1'b1;
            end
        end

        foreach (run_bytes[k])
        begin
            w = '{run_bytes[k][7:0], run_bytes[k][8], 1'b0, 2'd0, 16'h0000, 16'h0000};
            send_word(w);
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence: reset, the directed table, the random runs, then drain.
    // ------------------------------------------------------------------
    initial
    begin
        // Directed words: byte, final flag, typed, unit count, first and second
        // unit. Rows with typed clear are checked against the decoder above.
        directed_words = '{
            '{8'h00, 1'b0, 1'b1, 2'd1, 16'h0000, 16'h0000},  // lowest ASCII
            '{8'h7F, 1'b0, 1'b1, 2'd1, 16'h007F, 16'h0000},  // highest ASCII
            '{8'h80, 1'b0, 1'b1, 2'd1, REPLACEMENT, 16'h0000},  // stray continuation
            '{8'hFF, 1'b0, 1'b1, 2'd1, REPLACEMENT, 16'h0000},  // invalid lead
            '{8'hC3, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},  // two-byte sequence
            '{8'hA9, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
            '{8'hE2, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},  // three-byte sequence
            '{8'h82, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
            '{8'hAC, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
            '{8'hF0, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},  // four bytes, surrogate pair
            '{8'h9F, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
            '{8'h98, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
            '{8'h80, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
            '{8'hF7, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},  // largest point, 21 ones
            '{8'hBF, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
            '{8'hBF, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
            '{8'hBF, 1'b0, 1'b1, 2'd2, 16'hDFBF, 16'hDFFF},
            '{8'hC3, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},  // broken by ASCII
            '{8'h41, 1'b0, 1'b1, 2'd2, REPLACEMENT, 16'h0041},
            '{8'hE2, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},  // broken by a bad lead
            '{8'h82, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
            '{8'hFF, 1'b0, 1'b1, 2'd2, REPLACEMENT, REPLACEMENT},
            '{8'hF0, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},  // cut off by end of stream
            '{8'h9F, 1'b1, 1'b1, 2'd1, REPLACEMENT, 16'h0000},
            '{8'hE2, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},  // broken, new lead cut off
            '{8'hC3, 1'b1, 1'b1, 2'd2, REPLACEMENT, REPLACEMENT},
            '{8'h41, 1'b1, 1'b1, 2'd1, 16'h0041, 16'h0000}   // one-byte stream
        };

        // Every input is known from time zero; reset is held low first and released at a falling edge.
        rst_n               = 1'b0;
        utf8_ch.valid       = 1'b0;
        utf8_ch.in_byte     = 8'h00;
        utf8_ch.final_byte  = 1'b0;
        utf16_ch.ready      = 1'b0;
        gathered_bits       = '0;
        cont_left           = 2'd0;
        byte_unit_count     = 0;
        current_word        = '0;
        no_stalls           = 1'b0;
        cycle_count         = 0;
        mismatches          = 0;
        bytes_sent          = 0;
        units_checked       = 0;
        surrogates_seen     = 0;
        replacements_seen   = 0;
        stream_ends_seen    = 0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_words[i])
            send_word(directed_words[i]);

        // A stretch of random runs in the middle goes with neither side idling,
        // so the job queue is pushed to full and back-to-back words are seen.
        while (bytes_sent < DIRECTED_COUNT + RANDOM_BYTES)
        begin
            no_stalls = (bytes_sent >= DIRECTED_COUNT + 300) &&
                        (bytes_sent <  DIRECTED_COUNT + 450);
            send_random_run();
        end
        no_stalls = 1'b0;
        utf8_ch.valid <= 1'b0;

        // Wait for every owed unit, then a little longer to catch any extra.
        while (units_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d bytes (%0d from the table), checked %0d code units.",
                 bytes_sent, DIRECTED_COUNT, units_checked);
        $display("Among them %0d surrogates, %0d replacements and %0d stream ends; %0d mismatches.",
                 surrogates_seen, replacements_seen, stream_ends_seen, mismatches);
        if (mismatches == 0 && units_due.size() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
